@@ rtl/poi_pkg.sv @@
// Shared constants for the planar odometry integrator.
package poi_pkg;

    localparam int TRIG_BITS_DEF = 14;

    localparam int STEP_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int M_W     = 33;
    localparam int ACC_W   = M_W + GAIN_W;
    localparam int REM_W   = 17;
    localparam int DIV_C   = 64000;
    localparam int ROUND_C = 32000;
    localparam int CNT_W   = 6;

    localparam logic [23:0] ANG_SCALE = 24'd10937044;

    localparam logic [2:0] CFG_DEFAULT_STEP = 3'd0;
    localparam logic [2:0] CFG_GAIN         = 3'd1;
    localparam logic [2:0] CFG_START_X      = 3'd2;
    localparam logic [2:0] CFG_START_Y      = 3'd3;
    localparam logic [2:0] CFG_START_HEAD   = 3'd4;

    localparam logic [16:0] QSIN [17] = '{
        17'd0,     17'd6424,  17'd12785, 17'd19024, 17'd25080, 17'd30893,
        17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
        17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

endpackage

@@ rtl/poi_lane.sv @@
// Bit-serial scale-by-step, scale-by-gain and divide-by-64000 lane for one axis.
module poi_lane #(
    parameter int TRIG_BITS = poi_pkg::TRIG_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [TRIG_BITS+16:0]       rmag,
    input  logic                        neg,
    input  logic [poi_pkg::STEP_W-1:0]  step,
    input  logic [poi_pkg::GAIN_W-1:0]  gain,
    output logic                        done,
    output logic [31:0]                 delta
);
    import poi_pkg::*;

    typedef enum logic [2:0] {L_IDLE, L_MUL1, L_MID, L_MUL2, L_ROUND, L_DIV} lstate_t;

    lstate_t                state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [STEP_W-1:0]      sh_reg;
    logic [GAIN_W-1:0]      gain_reg;
    logic [TRIG_BITS+16:0]  rmag_reg;
    logic                   neg_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [M_W-1:0]         m_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [31:0]            quo_reg;
    logic                   done_reg;

    logic [REM_W-1:0]       rem_sh;
    logic                   qbit;

    assign rem_sh = {rem_reg[REM_W-2:0], acc_reg[ACC_W-1]};
    assign qbit   = rem_sh >= REM_W'(DIV_C);
    assign done   = done_reg;
    assign delta  = neg_reg ? (32'd0 - quo_reg) : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            sh_reg    <= '0;
            gain_reg  <= '0;
            rmag_reg  <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            m_reg     <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        sh_reg    <= step;
                        gain_reg  <= gain;
                        rmag_reg  <= rmag;
                        neg_reg   <= neg;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= L_MUL1;
                    end
                end
                L_MUL1: begin
                    acc_reg <= (acc_reg << 1) + (sh_reg[STEP_W-1] ? ACC_W'(rmag_reg) : '0);
                    sh_reg  <= sh_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEP_W - 1)) begin
                        state_reg <= L_MID;
                    end
                end
                L_MID: begin
                    m_reg     <= acc_reg[TRIG_BITS +: M_W];
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_MUL2;
                end
                L_MUL2: begin
                    acc_reg  <= (acc_reg << 1) + (gain_reg[GAIN_W-1] ? ACC_W'(m_reg) : '0);
                    gain_reg <= gain_reg << 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(GAIN_W - 1)) begin
                        state_reg <= L_ROUND;
                    end
                end
                L_ROUND: begin
                    acc_reg   <= acc_reg + ACC_W'(ROUND_C);
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= L_DIV;
                end
                L_DIV: begin
                    rem_reg <= qbit ? (rem_sh - REM_W'(DIV_C)) : rem_sh;
                    quo_reg <= {quo_reg[30:0], qbit};
                    acc_reg <= acc_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ACC_W - 1)) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/planar_odometry_integrator.sv @@
// Planar dead-reckoning odometry integrator top level.
// An update computes the heading sine and cosine, then the rotated velocity, then per
// axis a bit-serial multiply by the step, by the gain and a restoring divide by 64000,
// with both axes in parallel lanes. A restart skips the lanes and goes straight to the
// finish state, which waits while an earlier result is still held. One update is in
// flight at a time; the result register holds a finished pose until it is taken.
module planar_odometry_integrator #(
    parameter int TRIG_BITS = poi_pkg::TRIG_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // tick_ms, vel_x, vel_y, yaw_rate
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // pos_x, pos_y, heading, step_used_ms
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import poi_pkg::*;

    localparam int TS_W = TRIG_BITS + 2;
    localparam int RS_W = TRIG_BITS + 18;

    typedef enum logic [2:0] {S_IDLE, S_TRIG, S_PROD, S_LAUNCH, S_RUN, S_FINISH} state_t;

    function automatic logic signed [TS_W-1:0] bam_sin(input logic [15:0] h);
        logic [1:0]  quad;
        logic [14:0] p;
        logic [4:0]  i;
        logic [16:0] a;
        logic [16:0] b;
        logic [26:0] prod;
        logic [16:0] qv;
        logic [TS_W-1:0] v;
        quad = h[15:14];
        p    = {1'b0, h[13:0]};
        if (quad[0]) begin
            p = 15'h4000 - p;
        end
        i = p[14:10];
        if (i >= 5'd16) begin
            qv = QSIN[16];
        end else begin
            a    = QSIN[i];
            b    = QSIN[5'(i + 5'd1)];
            prod = 27'(b - a) * 27'(p[9:0]);
            qv   = a + 17'(prod >> 10);
        end
        v = TS_W'(qv >> (16 - TRIG_BITS));
        return quad[1] ? $signed(-v) : $signed(v);
    endfunction

    state_t                  state_reg;
    logic [15:0]             cfg_step_reg;
    logic [15:0]             cfg_gain_reg;
    logic [31:0]             cfg_x_reg;
    logic [31:0]             cfg_y_reg;
    logic [15:0]             cfg_head_reg;
    logic [31:0]             last_tick_reg;
    logic [31:0]             x_acc_reg;
    logic [31:0]             y_acc_reg;
    logic [15:0]             head_acc_reg;
    logic [15:0]             step_reg;
    logic                    restart_reg;
    logic signed [15:0]      vx_reg;
    logic signed [15:0]      vy_reg;
    logic signed [15:0]      wz_reg;
    logic signed [TS_W-1:0]  s_reg;
    logic signed [TS_W-1:0]  c_reg;
    logic signed [RS_W-1:0]  rx_reg;
    logic signed [RS_W-1:0]  ry_reg;
    logic [30:0]             pmag_reg;
    logic                    pneg_reg;
    logic [15:0]             hd_reg;
    logic                    m_tvalid_reg;
    logic [95:0]             m_tdata_reg;

    logic [31:0]             tick_diff;
    logic [15:0]             step_new;
    logic signed [RS_W-1:0]  vxw, vyw, sw, cw;
    logic signed [31:0]      pw;
    logic [54:0]             hsum;
    logic [15:0]             hm;
    logic [RS_W-1:0]         rx_abs, ry_abs;
    logic                    lane_start;
    logic                    x_done, y_done;
    logic [31:0]             dx, dy;
    logic [31:0]             nx, ny;
    logic [15:0]             nh;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign tick_diff = s_tdata[31:0] - last_tick_reg;
    assign step_new  = (last_tick_reg == 32'd0) ? cfg_step_reg :
                       ((tick_diff[31:16] != 16'd0) ? 16'hFFFF : tick_diff[15:0]);

    assign vxw = RS_W'(vx_reg);
    assign vyw = RS_W'(vy_reg);
    assign sw  = RS_W'(s_reg);
    assign cw  = RS_W'(c_reg);
    assign pw  = 32'(wz_reg) * $signed({16'd0, step_reg});

    assign hsum = 55'(pmag_reg) * 55'(ANG_SCALE) + 55'(33'h080000000);
    assign hm   = hsum[47:32];

    assign rx_abs = rx_reg[RS_W-1] ? RS_W'(-rx_reg) : RS_W'(rx_reg);
    assign ry_abs = ry_reg[RS_W-1] ? RS_W'(-ry_reg) : RS_W'(ry_reg);
    assign lane_start = (state_reg == S_LAUNCH);

    assign nx = restart_reg ? x_acc_reg : x_acc_reg + dx;
    assign ny = restart_reg ? y_acc_reg : y_acc_reg + dy;
    assign nh = restart_reg ? head_acc_reg : head_acc_reg + hd_reg;

    poi_lane #(.TRIG_BITS(TRIG_BITS)) u_lane_x (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start),
        .rmag(rx_abs[RS_W-2:0]), .neg(rx_reg[RS_W-1]),
        .step(step_reg), .gain(cfg_gain_reg), .done(x_done), .delta(dx)
    );

    poi_lane #(.TRIG_BITS(TRIG_BITS)) u_lane_y (
        .aclk(aclk), .aresetn(aresetn), .start(lane_start),
        .rmag(ry_abs[RS_W-2:0]), .neg(ry_reg[RS_W-1]),
        .step(step_reg), .gain(cfg_gain_reg), .done(y_done), .delta(dy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cfg_step_reg  <= 16'd1;
            cfg_gain_reg  <= 16'd18022;
            cfg_x_reg     <= '0;
            cfg_y_reg     <= '0;
            cfg_head_reg  <= '0;
            last_tick_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            head_acc_reg  <= '0;
            step_reg      <= '0;
            restart_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEFAULT_STEP: cfg_step_reg <= cfg_wdata[15:0];
                    CFG_GAIN:         cfg_gain_reg <= cfg_wdata[15:0];
                    CFG_START_X:      cfg_x_reg    <= cfg_wdata;
                    CFG_START_Y:      cfg_y_reg    <= cfg_wdata;
                    CFG_START_HEAD:   cfg_head_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != S_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[0]) begin
                            x_acc_reg     <= cfg_x_reg;
                            y_acc_reg     <= cfg_y_reg;
                            head_acc_reg  <= cfg_head_reg;
                            last_tick_reg <= '0;
                            step_reg      <= '0;
                            restart_reg   <= 1'b1;
                            state_reg     <= S_FINISH;
                        end else begin
                            step_reg      <= step_new;
                            last_tick_reg <= s_tdata[31:0];
                            vx_reg        <= s_tdata[47:32];
                            vy_reg        <= s_tdata[63:48];
                            wz_reg        <= s_tdata[79:64];
                            restart_reg   <= 1'b0;
                            state_reg     <= S_TRIG;
                        end
                    end
                end
                S_TRIG: begin
                    s_reg     <= bam_sin(head_acc_reg);
                    c_reg     <= bam_sin(head_acc_reg + 16'h4000);
                    state_reg <= S_PROD;
                end
                S_PROD: begin
                    rx_reg    <= vxw * cw - vyw * sw;
                    ry_reg    <= vxw * sw + vyw * cw;
                    pneg_reg  <= pw[31];
                    pmag_reg  <= pw[31] ? 31'(-pw) : pw[30:0];
                    state_reg <= S_LAUNCH;
                end
                S_LAUNCH: begin
                    hd_reg    <= pneg_reg ? (16'd0 - hm) : hm;
                    state_reg <= S_RUN;
                end
                S_RUN: begin
                    if (x_done) begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        x_acc_reg    <= nx;
                        y_acc_reg    <= ny;
                        head_acc_reg <= nh;
                        m_tdata_reg  <= {step_reg, nh, ny, nx};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        x_done == y_done)
        else $error("axis lanes finished out of step");

    a_restart_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg) && restart_reg) |-> (m_tdata_reg[95:80] == 16'd0))
        else $error("restart result carries nonzero step");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while busy");

endmodule

@@ test/poi_checker.sv @@
// Pose predictor and result checker for the planar odometry integrator.
module poi_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output int          fail_count,
    output int          pending_poses
);
    import poi_pkg::*;

    localparam int TB_TRIG = TRIG_BITS_DEF;

    logic [95:0] pose_q[$];

    logic [31:0] last_tick, x_acc, y_acc;
    logic [15:0] head_acc;
    logic [15:0] c_step, c_gain, c_head;
    logic [31:0] c_x, c_y;

    function automatic longint quarter_wave(int unsigned p);
        int unsigned i, f;
        longint a, b;
        i = p >> 10;
        f = p & 1023;
        if (i >= 16) return 65536;
        a = QSIN[i];
        b = QSIN[i + 1];
        return a + (((b - a) * f) >>> 10);
    endfunction

    function automatic longint angle_sin(logic [15:0] h);
        int unsigned q, p;
        longint v;
        q = h[15:14];
        p = h[13:0];
        if (q[0]) p = 16384 - p;
        v = quarter_wave(p) >>> (16 - TB_TRIG);
        return q[1] ? -v : v;
    endfunction

    function automatic logic [31:0] axis_delta(longint r, logic [15:0] st, logic [15:0] g);
        logic [127:0] m;
        logic neg;
        neg = r < 0;
        m = neg ? -r : r;
        m = (m * st) >> TB_TRIG;
        m = (m * g + 32000) / 64000;
        return neg ? -m[31:0] : m[31:0];
    endfunction

    task automatic predict_pose(logic cmd, logic [79:0] d);
        logic [31:0] tick, dt;
        logic [15:0] st;
        longint vx, vy, wz, s, c, pw;
        logic [127:0] mag;
        logic [31:0] dx, dy;
        st = 0;
        if (cmd) begin
            last_tick = 0; x_acc = c_x; y_acc = c_y; head_acc = c_head;
        end else begin
            tick = d[31:0];
            vx = $signed(d[47:32]);
            vy = $signed(d[63:48]);
            wz = $signed(d[79:64]);
            if (last_tick == 0) begin
                st = c_step;
            end else begin
                dt = tick - last_tick;
                st = (dt > 65535) ? 16'hFFFF : dt[15:0];
            end
            last_tick = tick;
            s = angle_sin(head_acc);
            c = angle_sin(head_acc + 16'h4000);
            dx = axis_delta(vx * c - vy * s, st, c_gain);
            dy = axis_delta(vx * s + vy * c, st, c_gain);
            x_acc += dx;
            y_acc += dy;
            pw = wz * longint'(st);
            mag = (pw < 0) ? -pw : pw;
            mag = (mag * 10937044 + 128'h80000000) >> 32;
            if (pw < 0) mag = -mag;
            head_acc = head_acc + mag[15:0];
        end
        pose_q.push_back({st, head_acc, y_acc, x_acc});
    endtask

    always @(posedge aclk) begin
        logic [95:0] want;
        if (!aresetn) begin
            last_tick = 0; x_acc = 0; y_acc = 0; head_acc = 0;
            c_step = 1; c_gain = 18022; c_x = 0; c_y = 0; c_head = 0;
            fail_count = 0;
            pose_q.delete();
            pending_poses = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DEFAULT_STEP: c_step = cfg_wdata[15:0];
                    CFG_GAIN:         c_gain = cfg_wdata[15:0];
                    CFG_START_X:      c_x = cfg_wdata;
                    CFG_START_Y:      c_y = cfg_wdata;
                    CFG_START_HEAD:   c_head = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_pose(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = pose_q.pop_front();
                    if (want[31:0] !== m_tdata[31:0])
                        $display("%0t: pos_x exp %h got %h", $time, want[31:0], m_tdata[31:0]);
                    if (want[63:32] !== m_tdata[63:32])
                        $display("%0t: pos_y exp %h got %h", $time, want[63:32],
                                 m_tdata[63:32]);
                    if (want[79:64] !== m_tdata[79:64])
                        $display("%0t: heading exp %h got %h", $time, want[79:64],
                                 m_tdata[79:64]);
                    if (want[95:80] !== m_tdata[95:80])
                        $display("%0t: step exp %h got %h", $time, want[95:80],
                                 m_tdata[95:80]);
                    if (want !== m_tdata) fail_count++;
                end
            end
            pending_poses = pose_q.size();
        end
    end
endmodule

@@ test/tb_top.sv @@
// Stimulus and verdict for the planar odometry integrator.
module tb_top;
    import poi_pkg::*;

    logic        aclk = 0, aresetn = 0;
    logic        s_tvalid = 0, m_tready = 0;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tready, m_tvalid;
    logic [95:0] m_tdata;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    int          fail_count, pending_poses;
    int          send_idle = 0, recv_stall = 0;
    bit          hold_off = 0;
    logic [31:0] tick_now = 1;

    planar_odometry_integrator dut (.*);
    poi_checker chk (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(logic [2:0] a, logic [31:0] v);
        cfg_we <= 1; cfg_addr <= a; cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic drain_poses();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_poses != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic send_item(logic cmd, logic [31:0] tk, logic [15:0] vx, logic [15:0] vy,
                             logic [15:0] wz);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= cmd; s_tdata <= {wz, vy, vx, tk};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic random_item();
        int k;
        logic [31:0] tk;
        k = $urandom_range(99);
        if (k < 4) begin
            send_item(1, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
            return;
        end
        if (k < 80) tick_now += $urandom_range(40);
        else if (k < 88) tick_now += $urandom_range(200000);
        else if (k < 92) tick_now -= $urandom_range(1000);
        else if (k < 95) tick_now = 0;
        else tick_now = $urandom;
        tk = tick_now;
        send_item(0, tk, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic set_config(int mode);
        case (mode)
            0: begin
                write_reg(CFG_DEFAULT_STEP, 32'hFFFF); write_reg(CFG_GAIN, 32'hFFFF);
                write_reg(CFG_START_X, 32'h7FFF_FFFF); write_reg(CFG_START_Y, 32'h8000_0000);
                write_reg(CFG_START_HEAD, 32'hFFFF);
            end
            1: begin
                write_reg(CFG_DEFAULT_STEP, 0); write_reg(CFG_GAIN, 0);
                write_reg(CFG_START_X, 0); write_reg(CFG_START_Y, 32'hFFFF_FFFF);
                write_reg(CFG_START_HEAD, 32'h4000);
            end
            default: begin
                write_reg(CFG_DEFAULT_STEP, $urandom_range(100));
                write_reg(CFG_GAIN, $urandom);
                write_reg(CFG_START_X, $urandom); write_reg(CFG_START_Y, $urandom);
                write_reg(CFG_START_HEAD, $urandom);
            end
        endcase
        cfg_we <= 0;
    endtask

    initial begin
        int ph;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: first update, extremes, zero tick, equal stamps, backward clock, restart
        send_item(0, 100, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(0, 110, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(0, 110, 16'h0100, 16'h0000, 16'h1000);
        send_item(0, 50, 16'h0100, 16'h0100, 16'h0000);
        send_item(0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_item(0, 0, 16'h0200, 16'hFF00, 16'h0800);
        send_item(0, 5, 16'h0200, 16'hFF00, 16'h0800);
        send_item(1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(0, 7, 16'h0000, 16'h0000, 16'h0000);
        drain_poses();
        for (ph = 0; ph < 8; ph++) begin
            set_config(ph < 2 ? ph : 2);
            send_item(1, 0, 0, 0, 0);
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 71; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 71; end
                default: begin send_idle = 26; recv_stall = 26; end
            endcase
            if (ph == 4) begin
                hold_off = 1;
                fork
                    begin repeat (600) @(posedge aclk); hold_off = 0; end
                    repeat (20) random_item();
                join
            end
            repeat (160) random_item();
            drain_poses();
        end
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule

@@ planar_odometry_integrator.f @@
rtl/poi_pkg.sv
rtl/poi_lane.sv
rtl/planar_odometry_integrator.sv
test/poi_checker.sv
test/tb_top.sv
